FILE: hw/rtl/rdcd_pkg.sv
package rdcd_pkg;

    localparam int FRAME_BYTES = 34;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int GAIN_COUNT  = 6;
    localparam int SPEED_W     = 15;
    localparam int WORD_W      = 32;

    localparam int SIGN_LEFT   = 24;
    localparam int SIGN_RIGHT  = 29;

    localparam logic [7:0] BYTE_START = 8'hF0;
    localparam logic [7:0] BYTE_END   = 8'hFF;
    localparam logic [7:0] CMD_SET    = 8'h6D;  // 'm'
    localparam logic [7:0] CMD_CLEAR  = 8'h70;  // 'p'
    localparam logic [7:0] CMD_START  = 8'h73;  // 's'
    localparam logic [7:0] CMD_STOP   = 8'h53;  // 'S'
    localparam logic [5:0] DIGIT_HIGH = 6'b001100;  // '0'..'3' share these upper bits

    localparam logic [SPEED_W-1:0] CRUISE_RESET = 15'd100;
    localparam logic [SPEED_W-1:0] TURN_RESET   = 15'd150;

    localparam logic [WORD_W-1:0] GAIN_ONE       = 32'h3F80_0000;
    localparam logic [WORD_W-1:0] GAIN_HUNDREDTH = 32'h3C23_D70A;

    typedef enum logic [0:0]
    {
        CFG_CRUISE = 1'b0,
        CFG_TURN   = 1'b1
    } cfg_index_t;

    typedef logic [GAIN_COUNT-1:0][WORD_W-1:0] gain_words_t;

    typedef struct packed
    {
        logic              load;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } frame_load_t;

    typedef struct packed
    {
        logic claim;
        logic loaded;
        logic error;
    } frame_status_t;

endpackage

FILE: hw/rtl/remote_drive_command_decoder_core.sv
// Channel   Signals                           Transfer
// in        in_valid, in_ready, mode, rx_byte in_valid && in_ready
// out       out_valid, out_ready, result ports out_valid && out_ready
// cfg       cfg_we, cfg_index, cfg_data       cfg_we
//
// One item per cycle while in_ready is high; the result shows the cycle after transfer.
// State registers double as the result register; the pulse flags are registered at transfer.
// in_ready falls only while a result is held and out_ready is low.
// Reset restores default gains, zero targets and the default speeds.
module remote_drive_command_decoder_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    left_kp,
    output logic [31:0]                    left_ki,
    output logic [31:0]                    left_kd,
    output logic [31:0]                    right_kp,
    output logic [31:0]                    right_ki,
    output logic [31:0]                    right_kd,
    output logic signed [31:0]             left_target,
    output logic signed [31:0]             right_target,
    output logic                           running,
    output logic                           clear_controllers,
    output logic                           frame_loaded,
    output logic                           frame_error,
    input  logic                           cfg_we,
    input  rdcd_pkg::cfg_index_t           cfg_index,
    input  logic [rdcd_pkg::SPEED_W-1:0]   cfg_data
);
    import rdcd_pkg::*;

    logic               accept;
    logic               byte_en;
    logic               await_any;
    logic               stop_pulse;
    frame_status_t      fstatus;
    frame_load_t        fload;
    gain_words_t        gains;
    logic [WORD_W-1:0]  left_word;
    logic [WORD_W-1:0]  right_word;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               clr_reg;
    logic               loaded_reg;
    logic               error_reg;
    logic [SPEED_W-1:0] cruise_reg;
    logic [SPEED_W-1:0] turn_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign byte_en  = accept && !mode && !await_any;

    rdcd_frame u_frame
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (rx_byte),
        .status  (fstatus),
        .load    (fload),
        .gains   (gains)
    );

    rdcd_drive u_drive
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (accept),
        .mode         (mode),
        .rx_byte      (rx_byte),
        .frame_claim  (fstatus.claim),
        .load         (fload),
        .cruise_speed (cruise_reg),
        .turn_speed   (turn_reg),
        .await_any    (await_any),
        .stop_pulse   (stop_pulse),
        .running      (running),
        .left_target  (left_word),
        .right_target (right_word)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_reg       <= 1'b0;
            loaded_reg    <= 1'b0;
            error_reg     <= 1'b0;
            cruise_reg    <= CRUISE_RESET;
            turn_reg      <= TURN_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                clr_reg    <= stop_pulse;
                loaded_reg <= fstatus.loaded;
                error_reg  <= fstatus.error;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CRUISE: cruise_reg <= cfg_data;
                    CFG_TURN:   turn_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign left_kp           = gains[0];
    assign left_ki           = gains[1];
    assign left_kd           = gains[2];
    assign right_kp          = gains[3];
    assign right_ki          = gains[4];
    assign right_kd          = gains[5];
    assign left_target       = left_word;
    assign right_target      = right_word;
    assign clear_controllers = clr_reg;
    assign frame_loaded      = loaded_reg;
    assign frame_error       = error_reg;

endmodule

FILE: hw/rtl/rdcd_frame.sv
module rdcd_frame
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_en,
    input  logic [7:0]           rx_byte,
    output rdcd_pkg::frame_status_t status,
    output rdcd_pkg::frame_load_t   load,
    output rdcd_pkg::gain_words_t   gains
);
    import rdcd_pkg::*;

    logic [7:0]         shadow_reg [FRAME_BYTES];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               in_frame_reg;
    logic               in_frame_next;
    gain_words_t        gains_reg;
    gain_words_t        gains_next;
    gain_words_t        shadow_gains;
    logic               full;
    logic               wr_en;
    logic               is_end;
    logic [WORD_W-1:0]  mag_left;
    logic [WORD_W-1:0]  mag_right;

    assign full   = (count_reg >= COUNT_W'(FRAME_BYTES));
    assign is_end = (rx_byte == BYTE_END);
    assign wr_en  = byte_en && in_frame_reg && !is_end && !full;

    always_comb
    begin
        for (int k = 0; k < GAIN_COUNT; k++)
        begin
            shadow_gains[k] = {shadow_reg[4*k+3], shadow_reg[4*k+2],
                               shadow_reg[4*k+1], shadow_reg[4*k]};
        end
        mag_left  = {shadow_reg[SIGN_LEFT+4], shadow_reg[SIGN_LEFT+3],
                     shadow_reg[SIGN_LEFT+2], shadow_reg[SIGN_LEFT+1]};
        mag_right = {shadow_reg[SIGN_RIGHT+4], shadow_reg[SIGN_RIGHT+3],
                     shadow_reg[SIGN_RIGHT+2], shadow_reg[SIGN_RIGHT+1]};
    end

    always_comb
    begin
        count_next    = count_reg;
        in_frame_next = in_frame_reg;
        gains_next    = gains_reg;
        status.claim  = in_frame_reg || (rx_byte == BYTE_START);
        status.loaded = 1'b0;
        status.error  = 1'b0;
        load.load     = 1'b0;
        load.left     = (shadow_reg[SIGN_LEFT] != 8'd0) ? (32'd0 - mag_left) : mag_left;
        load.right    = (shadow_reg[SIGN_RIGHT] != 8'd0) ? (32'd0 - mag_right) : mag_right;
        if (byte_en)
        begin
            if (in_frame_reg)
            begin
                if (is_end)
                begin
                    in_frame_next = 1'b0;
                    if (full)
                    begin
                        gains_next    = shadow_gains;
                        load.load     = 1'b1;
                        status.loaded = 1'b1;
                    end
                    else
                    begin
                        status.error = 1'b1;
                    end
                end
                else if (!full)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            else if (rx_byte == BYTE_START)
            begin
                in_frame_next = 1'b1;
                count_next    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (wr_en && (count_reg == COUNT_W'(i)))
            begin
                shadow_reg[i] <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            in_frame_reg <= 1'b0;
            gains_reg    <= {GAIN_ONE, GAIN_HUNDREDTH, GAIN_ONE,
                             GAIN_ONE, GAIN_HUNDREDTH, GAIN_ONE};
        end
        else
        begin
            count_reg    <= count_next;
            in_frame_reg <= in_frame_next;
            gains_reg    <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

FILE: hw/rtl/rdcd_drive.sv
module rdcd_drive
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step_en,
    input  logic                             mode,
    input  logic [7:0]                       rx_byte,
    input  logic                             frame_claim,
    input  rdcd_pkg::frame_load_t            load,
    input  logic [rdcd_pkg::SPEED_W-1:0]     cruise_speed,
    input  logic [rdcd_pkg::SPEED_W-1:0]     turn_speed,
    output logic                             await_any,
    output logic                             stop_pulse,
    output logic                             running,
    output logic [rdcd_pkg::WORD_W-1:0]      left_target,
    output logic [rdcd_pkg::WORD_W-1:0]      right_target
);
    import rdcd_pkg::*;

    logic [3:0]        flags_reg;
    logic [3:0]        flags_next;
    logic              await_set_reg;
    logic              await_set_next;
    logic              await_clear_reg;
    logic              await_clear_next;
    logic              fta_reg;
    logic              fta_next;
    logic              run_reg;
    logic              run_next;
    logic [WORD_W-1:0] left_reg;
    logic [WORD_W-1:0] left_next;
    logic [WORD_W-1:0] right_reg;
    logic [WORD_W-1:0] right_next;
    logic [WORD_W-1:0] c_pos;
    logic [WORD_W-1:0] c_neg;
    logic [WORD_W-1:0] t_pos;
    logic [WORD_W-1:0] t_neg;
    logic              is_digit;
    logic [3:0]        digit_mask;

    assign c_pos      = {{(WORD_W-SPEED_W){1'b0}}, cruise_speed};
    assign t_pos      = {{(WORD_W-SPEED_W){1'b0}}, turn_speed};
    assign c_neg      = 32'd0 - c_pos;
    assign t_neg      = 32'd0 - t_pos;
    assign is_digit   = (rx_byte[7:2] == DIGIT_HIGH);
    assign digit_mask = 4'b0001 << rx_byte[1:0];

    always_comb
    begin
        flags_next       = flags_reg;
        await_set_next   = await_set_reg;
        await_clear_next = await_clear_reg;
        fta_next         = fta_reg;
        run_next         = run_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        stop_pulse       = 1'b0;
        if (step_en)
        begin
            if (mode)
            begin
                if (run_reg)
                begin
                    if (flags_reg == 4'd0)
                    begin
                        if (!fta_reg)
                        begin
                            left_next  = '0;
                            right_next = '0;
                        end
                    end
                    else if (flags_reg[0])
                    begin
                        left_next  = flags_reg[2] ? c_pos : (flags_reg[3] ? t_pos : c_pos);
                        right_next = flags_reg[2] ? t_pos : c_pos;
                    end
                    else if (flags_reg[1])
                    begin
                        left_next  = flags_reg[2] ? c_neg : (flags_reg[3] ? t_neg : c_neg);
                        right_next = flags_reg[2] ? t_neg : c_neg;
                    end
                    else if (flags_reg[2])
                    begin
                        left_next  = c_neg;
                        right_next = c_pos;
                    end
                    else
                    begin
                        left_next  = c_pos;
                        right_next = c_neg;
                    end
                end
            end
            else if (await_set_reg)
            begin
                await_set_next = 1'b0;
                if (is_digit)
                begin
                    flags_next = flags_reg | digit_mask;
                    fta_next   = 1'b0;
                end
            end
            else if (await_clear_reg)
            begin
                await_clear_next = 1'b0;
                if (is_digit)
                begin
                    flags_next = flags_reg & ~digit_mask;
                end
            end
            else if (frame_claim)
            begin
                if (load.load)
                begin
                    left_next  = load.left;
                    right_next = load.right;
                    fta_next   = 1'b1;
                end
            end
            else
            begin
                case (rx_byte)
                    CMD_SET:   await_set_next   = 1'b1;
                    CMD_CLEAR: await_clear_next = 1'b1;
                    CMD_START: run_next         = 1'b1;
                    CMD_STOP:
                    begin
                        run_next   = 1'b0;
                        stop_pulse = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg       <= '0;
            await_set_reg   <= 1'b0;
            await_clear_reg <= 1'b0;
            fta_reg         <= 1'b0;
            run_reg         <= 1'b0;
            left_reg        <= '0;
            right_reg       <= '0;
        end
        else
        begin
            flags_reg       <= flags_next;
            await_set_reg   <= await_set_next;
            await_clear_reg <= await_clear_next;
            fta_reg         <= fta_next;
            run_reg         <= run_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
        end
    end

    assign await_any    = await_set_reg || await_clear_reg;
    assign running      = run_reg;
    assign left_target  = left_reg;
    assign right_target = right_reg;

endmodule
